/* src/npc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// shared types and constants of the next burst prefetch cursor unit
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int BURST_W  = 16;
  localparam int CURSOR_W = 17;
  localparam int CORE_W   = 3;
  localparam int CREDIT_W = 5;
  localparam int DIST_W   = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic REQ_DEMAND = 1'b0;
  localparam logic REQ_TILE   = 1'b1;

  // register select bit of paddr, one word per register
  localparam logic REG_DISTANCE = 1'b0;

  localparam logic [DIST_W-1:0] DIST_RESET = 5'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ISSUE,
    S_EMPTY
  } state_t;

endpackage

/* src/npc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_in_if / npc_out_if
// valid/ready channels of the next burst prefetch cursor unit
// ----------------------------------------------------------------------------
interface npc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [2:0]  core_id;
  logic [15:0] burst_index;
  logic [15:0] bursts_in_tile;
  logic [4:0]  credits;

  modport source (output valid, req_type, core_id, burst_index, bursts_in_tile, credits,
                  input ready);
  modport sink (input valid, req_type, core_id, burst_index, bursts_in_tile, credits,
                output ready);
endinterface

interface npc_out_if;
  logic        valid;
  logic        ready;
  logic        prefetch_valid;
  logic [2:0]  issued_core;
  logic [15:0] prefetch_burst;
  logic        last_result;

  modport source (output valid, prefetch_valid, issued_core, prefetch_burst, last_result,
                  input ready);
  modport sink (input valid, prefetch_valid, issued_core, prefetch_burst, last_result,
                output ready);
endinterface

/* src/npc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module npc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/next_burst_prefetch_cursor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_burst_prefetch_cursor_unit
// per-core prefetch cursor table with next-n-burst request issue
//
// channel   dir   handshake                     payload
// in_if     in    valid/ready                   req_type core_id burst_index
//                                               bursts_in_tile credits
// out_if    out   valid/ready                   prefetch_valid issued_core
//                                               prefetch_burst last_result
// cfg       in    apb psel/penable, pready=1    burst lookahead at paddr 0
//
// demand word: accept with the cursor ram read, a load state, then one result
// word per cycle while the output slot is free; an empty result is one word
// tile start or out-of-range core: one empty result word
// the cursor table is cleared at reset through one valid flop per core
// output stalls hold the issue loop; a new word is taken once the last result
// of the previous word sits in the output register
// ----------------------------------------------------------------------------
module next_burst_prefetch_cursor_unit
  import npc_pkg::*;
#(
  parameter int CORE_COUNT   = 8,
  parameter int MAX_DISTANCE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  npc_in_if.sink            in_if,
  npc_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam logic [8:0] CORE_LIM = 9'(CORE_COUNT);
  localparam logic [6:0] MAXD     = 7'(MAX_DISTANCE);

  state_t                state_r, state_nxt;
  logic [DIST_W-1:0]     dist_r;
  logic [CORE_COUNT-1:0] vld_r, vld_nxt;
  logic                  vld_q_r, vld_q_nxt;
  logic [CORE_W-1:0]     core_r, core_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [BURST_W-1:0]    k_r, k_nxt;
  logic [BURST_W-1:0]    nb_r, nb_nxt;
  logic [CREDIT_W-1:0]   cred_r, cred_nxt;
  logic [CURSOR_W-1:0]   cur_r, cur_nxt;
  logic [CURSOR_W-1:0]   limit_r, limit_nxt;

  logic                  ov_r, ov_nxt;
  logic                  opv_r, opv_nxt;
  logic [CORE_W-1:0]     ocore_r, ocore_nxt;
  logic [BURST_W-1:0]    oburst_r, oburst_nxt;
  logic                  olast_r, olast_nxt;

  logic                  ram_we, ram_re;
  logic [CURSOR_W-1:0]   ram_wdata, ram_rdata;
  logic [AW-1:0]         in_addr;
  logic                  in_range, accept, slot_free, cfg_wr;
  logic [6:0]            dist_eff;
  logic [CURSOR_W-1:0]   cur_base, k_inc, cur_inc;
  logic                  cond_now, cond_next;

  npc_ram #(
    .WIDTH(CURSOR_W),
    .DEPTH(CORE_COUNT)
  ) u_cursor_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {{(CFG_DW-DIST_W){1'b0}}, dist_r};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DISTANCE);

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign in_addr     = AW'(in_if.core_id);
  assign in_range    = {6'b0, in_if.core_id} < CORE_LIM;
  assign slot_free   = !ov_r || out_if.ready;

  assign out_if.valid          = ov_r;
  assign out_if.prefetch_valid = opv_r;
  assign out_if.issued_core    = ocore_r;
  assign out_if.prefetch_burst = oburst_r;
  assign out_if.last_result    = olast_r;

  always_comb begin
    if (dist_r == '0) begin
      dist_eff = 7'd1;
    end else if ({2'b0, dist_r} > MAXD) begin
      dist_eff = MAXD;
    end else begin
      dist_eff = {2'b0, dist_r};
    end
  end

  assign cur_base  = vld_q_r ? ram_rdata : '0;
  assign k_inc     = {1'b0, k_r} + 17'd1;
  assign cur_inc   = cur_r + 17'd1;
  assign cond_now  = (cur_r <= limit_r) && (cur_r < {1'b0, nb_r}) && (cred_r != '0);
  assign cond_next = (cur_inc <= limit_r) && (cur_inc < {1'b0, nb_r}) && (cred_r > 5'd1);

  always_comb begin
    state_nxt  = state_r;
    vld_nxt    = vld_r;
    vld_q_nxt  = vld_q_r;
    core_nxt   = core_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    nb_nxt     = nb_r;
    cred_nxt   = cred_r;
    cur_nxt    = cur_r;
    limit_nxt  = limit_r;
    ov_nxt     = ov_r && !out_if.ready;
    opv_nxt    = opv_r;
    ocore_nxt  = ocore_r;
    oburst_nxt = oburst_r;
    olast_nxt  = olast_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          core_nxt = in_if.core_id;
          addr_nxt = in_addr;
          k_nxt    = in_if.burst_index;
          nb_nxt   = in_if.bursts_in_tile;
          cred_nxt = in_if.credits;
          if (!in_range) begin
            state_nxt = S_EMPTY;
          end else if (in_if.req_type == REQ_TILE) begin
            vld_nxt[in_addr] = 1'b0;
            state_nxt        = S_EMPTY;
          end else begin
            ram_re    = 1'b1;
            vld_q_nxt = vld_r[in_addr];
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cur_nxt   = (cur_base < k_inc) ? k_inc : cur_base;
        limit_nxt = {1'b0, k_r} + 17'(dist_eff);
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocore_nxt = core_r;
          if (cond_now) begin
            opv_nxt    = 1'b1;
            oburst_nxt = cur_r[BURST_W-1:0];
            olast_nxt  = !cond_next;
            cur_nxt    = cur_inc;
            cred_nxt   = cred_r - 5'd1;
            if (!cond_next) begin
              ram_we           = 1'b1;
              ram_wdata        = cur_inc;
              vld_nxt[addr_r]  = 1'b1;
              state_nxt        = S_IDLE;
            end
          end else begin
            opv_nxt         = 1'b0;
            oburst_nxt      = '0;
            olast_nxt       = 1'b1;
            ram_we          = 1'b1;
            vld_nxt[addr_r] = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          opv_nxt    = 1'b0;
          ocore_nxt  = core_r;
          oburst_nxt = '0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
      dist_r  <= DIST_RESET;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr) begin
        dist_r <= pwdata[DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r  <= vld_q_nxt;
    core_r   <= core_nxt;
    addr_r   <= addr_nxt;
    k_r      <= k_nxt;
    nb_r     <= nb_nxt;
    cred_r   <= cred_nxt;
    cur_r    <= cur_nxt;
    limit_r  <= limit_nxt;
    opv_r    <= opv_nxt;
    ocore_r  <= ocore_nxt;
    oburst_r <= oburst_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

/* src/npc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_checker
// port-level checks of the next burst prefetch cursor unit
// ----------------------------------------------------------------------------
module npc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_prefetch_valid,
  input logic [15:0] out_prefetch_burst,
  input logic        out_last_result,
  input logic        psel,
  input logic        penable,
  input logic        pready
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefetch_burst)
      && $stable(out_last_result))
    else $error("stalled result word changed");

  // empty result closes its word and carries burst zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_prefetch_valid |-> out_last_result && (out_prefetch_burst == '0))
    else $error("empty result malformed");

  // no result word right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

  // no input taken until the previous word has produced its last result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind next_burst_prefetch_cursor_unit npc_checker u_npc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_prefetch_valid(out_if.prefetch_valid),
  .out_prefetch_burst(out_if.prefetch_burst),
  .out_last_result   (out_if.last_result),
  .psel              (psel),
  .penable           (penable),
  .pready            (pready)
);

/* tb/next_burst_prefetch_cursor_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_burst_prefetch_cursor_unit_tb
// self-checking bench for the per-core next burst prefetch cursor unit
//
// a directed list walks reset state, the extremes of every field, distance
// clamping, credit exhaustion and retry of refused bursts, then random words
// built mostly as tile-start plus ascending demand runs per core, with noise.
// every accepted word goes through a shadow cursor table that predicts the
// prefetch words; results are checked in order against that queue, while in
// some phases the channels stall at random. the distance register is
// rewritten between phases, only with the unit drained, and read back over apb.
// ----------------------------------------------------------------------------
module next_burst_prefetch_cursor_unit_tb;
  import npc_pkg::*;

  localparam int PERIOD     = 2;
  localparam int CORES      = 8;
  localparam int DIST_LIMIT = 16;
  localparam int SETTLE     = 4;
  localparam logic [CFG_AW-1:0] DISTANCE_ADDR = {REG_DISTANCE, 2'b00};

  typedef struct packed {
    logic                req_type;
    logic [CORE_W-1:0]   core_id;
    logic [BURST_W-1:0]  burst_index;
    logic [BURST_W-1:0]  bursts_in_tile;
    logic [CREDIT_W-1:0] credits;
  } word_t;

  typedef struct packed {
    logic               prefetch_valid;
    logic [CORE_W-1:0]  issued_core;
    logic [BURST_W-1:0] prefetch_burst;
    logic               last_result;
  } prefetch_t;

  typedef struct {
    bit                 set_dist;
    logic [DIST_W-1:0]  lookahead;
    word_t              w;
    bit                 typed;
    int                 exp_n;
    logic [BURST_W-1:0] exp_first;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  npc_in_if  in_ch ();
  npc_out_if out_ch ();

  next_burst_prefetch_cursor_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CURSOR_W-1:0] cursor_shadow [CORES];
  logic [DIST_W-1:0]   distance_shadow;
  prefetch_t           staged_prefetches [$];
  prefetch_t           awaited_prefetches [$];
  row_t                directed_rows [$];
  int                  tile_len [CORES];
  int                  demand_pos [CORES];
  int                  in_gap_max;
  int                  out_gap_max;
  int                  mismatches;

  always #(PERIOD / 2) clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic prefetch_t empty_word(input logic [CORE_W-1:0] core);
    prefetch_t p;
    p.prefetch_valid = 1'b0;
    p.issued_core    = core;
    p.prefetch_burst = '0;
    p.last_result    = 1'b1;
    return p;
  endfunction

  // shadow of the cursor table, fills staged_prefetches
  function automatic void predict_prefetches(input word_t w);
    int        span;
    int        k;
    int        cur;
    int        limit;
    int        left;
    prefetch_t p;
    staged_prefetches.delete();
    if (w.req_type == REQ_TILE) begin
      cursor_shadow[w.core_id] = '0;
      staged_prefetches.insert(staged_prefetches.size(), empty_word(w.core_id));
      return;
    end
    span = int'(distance_shadow);
    if (span < 1) span = 1;
    if (span > DIST_LIMIT) span = DIST_LIMIT;
    k = int'(w.burst_index);
    cur = int'(cursor_shadow[w.core_id]);
    if (cur < k + 1) cur = k + 1;
    limit = k + span;
    left = int'(w.credits);
    while (cur <= limit && cur < int'(w.bursts_in_tile) && left > 0) begin
      p.prefetch_valid = 1'b1;
      p.issued_core    = w.core_id;
      p.prefetch_burst = cur[BURST_W-1:0];
      p.last_result    = 1'b0;
      staged_prefetches.insert(staged_prefetches.size(), p);
      left--;
      cur++;
    end
    cursor_shadow[w.core_id] = cur[CURSOR_W-1:0];
    if (staged_prefetches.size() == 0)
      staged_prefetches.insert(0, empty_word(w.core_id));
    else
      staged_prefetches[staged_prefetches.size() - 1].last_result = 1'b1;
  endfunction

  function automatic void add_row(input bit set_dist, input int lookahead,
                                  input logic req_type, input int core, input int burst,
                                  input int n_burst, input int credits, input bit typed,
                                  input int exp_n, input int exp_first);
    row_t r;
    r.set_dist           = set_dist;
    r.lookahead          = lookahead[DIST_W-1:0];
    r.w.req_type         = req_type;
    r.w.core_id          = core[CORE_W-1:0];
    r.w.burst_index      = burst[BURST_W-1:0];
    r.w.bursts_in_tile   = n_burst[BURST_W-1:0];
    r.w.credits          = credits[CREDIT_W-1:0];
    r.typed              = typed;
    r.exp_n              = exp_n;
    r.exp_first          = exp_first[BURST_W-1:0];
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic word_t draw_word();
    word_t w;
    int    c;
    int    roll;
    roll = $urandom_range(0, 99);
    c = $urandom_range(0, CORES - 1);
    w.core_id = c[CORE_W-1:0];
    w.credits = CREDIT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                      : $urandom_range(0, 16));
    if (roll < 15) begin
      w.req_type       = 1'($urandom_range(0, 1));
      w.burst_index    = BURST_W'($urandom);
      w.bursts_in_tile = BURST_W'($urandom);
    end else if (roll < 25 || demand_pos[c] >= tile_len[c]) begin
      if ($urandom_range(0, 9) == 0) begin
        tile_len[c]   = $urandom_range(0, 65535);
        demand_pos[c] = (tile_len[c] > 0) ? $urandom_range(0, tile_len[c] - 1) : 0;
      end else begin
        tile_len[c]   = $urandom_range(1, 48);
        demand_pos[c] = 0;
      end
      w.req_type       = REQ_TILE;
      w.burst_index    = BURST_W'($urandom);
      w.bursts_in_tile = tile_len[c][BURST_W-1:0];
    end else begin
      w.req_type       = REQ_DEMAND;
      w.burst_index    = demand_pos[c][BURST_W-1:0];
      w.bursts_in_tile = tile_len[c][BURST_W-1:0];
      demand_pos[c] += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
    end
    return w;
  endfunction

  // drives one word and queues its prefetch words once it is taken
  task automatic send_word(input row_t r);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type       = r.w.req_type;
    in_ch.core_id        = r.w.core_id;
    in_ch.burst_index    = r.w.burst_index;
    in_ch.bursts_in_tile = r.w.bursts_in_tile;
    in_ch.credits        = r.w.credits;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_prefetches(r.w);
    if (r.typed) begin
      staged_prefetches.delete();
      for (int i = 0; i < r.exp_n; i++)
        staged_prefetches.insert(staged_prefetches.size(),
                                 '{1'b1, r.w.core_id, r.exp_first + i[BURST_W-1:0],
                                   (i == r.exp_n - 1)});
      if (r.exp_n == 0) staged_prefetches.insert(0, empty_word(r.w.core_id));
    end
    awaited_prefetches = {awaited_prefetches, staged_prefetches};
  endtask

  task automatic settle_unit();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (awaited_prefetches.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic distance_readback(input logic [DIST_W-1:0] want);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = DISTANCE_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(want))
      flag_mismatch($sformatf("distance readback %0h, want %0h", prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic distance_write(input logic [DIST_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = DISTANCE_ADDR;
    pwdata  = ($urandom & ~CFG_DW'(5'h1f)) | CFG_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    distance_shadow = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    distance_readback(value);
  endtask

  // result side: random stall before each word, then ready until it is taken
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : check_prefetches
    prefetch_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_prefetches.size() == 0) begin
        flag_mismatch($sformatf("unexpected word core %0d burst %0d",
                                out_ch.issued_core, out_ch.prefetch_burst));
      end else begin
        want = awaited_prefetches.pop_front();
        if (out_ch.prefetch_valid !== want.prefetch_valid)
          flag_mismatch($sformatf("prefetch_valid %b, want %b",
                                  out_ch.prefetch_valid, want.prefetch_valid));
        if (out_ch.issued_core !== want.issued_core)
          flag_mismatch($sformatf("issued_core %0d, want %0d",
                                  out_ch.issued_core, want.issued_core));
        if (out_ch.prefetch_burst !== want.prefetch_burst)
          flag_mismatch($sformatf("prefetch_burst %0d, want %0d",
                                  out_ch.prefetch_burst, want.prefetch_burst));
        if (out_ch.last_result !== want.last_result)
          flag_mismatch($sformatf("last_result %b, want %b",
                                  out_ch.last_result, want.last_result));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int   phase_gap_in [4];
    int   phase_gap_out [4];
    logic [DIST_W-1:0] phase_dist [4];
    row_t r;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_DEMAND;
    in_ch.core_id        = '0;
    in_ch.burst_index    = '0;
    in_ch.bursts_in_tile = '0;
    in_ch.credits        = '0;
    mismatches           = 0;
    in_gap_max           = 0;
    out_gap_max          = 0;
    distance_shadow      = DIST_RESET;
    foreach (cursor_shadow[i]) cursor_shadow[i] = '0;
    foreach (tile_len[i]) begin
      tile_len[i]   = 0;
      demand_pos[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    distance_readback(DIST_RESET);

    // reset distance, single step, refused burst kept
    add_row(0, 0, REQ_DEMAND, 0, 0, 100, 4, 1, 1, 1);
    add_row(0, 0, REQ_DEMAND, 0, 0, 100, 4, 1, 0, 0);
    add_row(0, 0, REQ_TILE, 0, 0, 100, 4, 1, 0, 0);
    add_row(0, 0, REQ_DEMAND, 0, 0, 100, 0, 1, 0, 0);
    add_row(0, 0, REQ_DEMAND, 0, 0, 100, 1, 1, 1, 1);
    // full distance and burst extremes
    add_row(1, 16, REQ_DEMAND, 1, 0, 65535, 16, 1, 16, 1);
    add_row(0, 0, REQ_DEMAND, 1, 65535, 65535, 31, 1, 0, 0);
    add_row(0, 0, REQ_DEMAND, 2, 65533, 65535, 31, 1, 1, 65534);
    add_row(0, 0, REQ_DEMAND, 3, 5, 0, 16, 1, 0, 0);
    // distance clamps
    add_row(1, 0, REQ_DEMAND, 4, 10, 1000, 16, 1, 1, 11);
    add_row(1, 31, REQ_DEMAND, 5, 100, 65535, 31, 1, 16, 101);
    add_row(1, 17, REQ_DEMAND, 6, 0, 65535, 20, 1, 16, 1);
    // tile end, credit limit and retry
    add_row(1, 5, REQ_DEMAND, 7, 200, 203, 16, 1, 2, 201);
    add_row(0, 0, REQ_DEMAND, 7, 198, 203, 16, 1, 0, 0);
    add_row(0, 0, REQ_DEMAND, 7, 300, 65535, 3, 1, 3, 301);
    add_row(0, 0, REQ_DEMAND, 7, 300, 65535, 2, 1, 2, 304);
    add_row(0, 0, REQ_TILE, 7, 65535, 65535, 31, 1, 0, 0);
    add_row(0, 0, REQ_DEMAND, 7, 0, 65535, 16, 1, 5, 1);
    add_row(0, 0, REQ_DEMAND, 3, 'haaaa, 'hffff, 'h15, 0, 0, 0);
    add_row(0, 0, REQ_DEMAND, 4, 'h5555, 'h5557, 'h0a, 0, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_dist) begin
        settle_unit();
        distance_write(directed_rows[i].lookahead);
      end
      send_word(directed_rows[i]);
    end

    phase_gap_in  = '{16, 0, 0, 16};
    phase_gap_out = '{16, 0, 16, 0};
    phase_dist    = '{5'd2, 5'd16, 5'd8, 5'($urandom_range(0, 31))};
    for (int p = 0; p < 4; p++) begin
      settle_unit();
      distance_write(phase_dist[p]);
      in_gap_max  = phase_gap_in[p];
      out_gap_max = phase_gap_out[p];
      for (int i = 0; i < 48; i++) begin
        r.set_dist  = 1'b0;
        r.lookahead = '0;
        r.typed     = 1'b0;
        r.exp_n     = 0;
        r.exp_first = '0;
        r.w         = draw_word();
        send_word(r);
      end
    end

    settle_unit();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/npc_pkg.sv
src/npc_if.sv
src/npc_ram.sv
src/next_burst_prefetch_cursor_unit.sv
src/npc_checker.sv
tb/next_burst_prefetch_cursor_unit_tb.sv
